[rtl/scf_pkg.sv]
// Shared types and constants of the SysEx chunk framer.
`default_nettype none
package scf_pkg;

  localparam int CHUNK_MAX = 48;
  localparam int IDX_W     = 6;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  localparam logic [7:0] SOF_BYTE   = 8'hF0;
  localparam logic [7:0] EOF_BYTE   = 8'hF7;
  localparam logic [7:0] FLAG_CONT  = 8'h10;
  localparam logic [7:0] FLAG_FINAL = 8'h20;

  localparam logic [1:0] REG_MFG_FIRST  = 2'd0;
  localparam logic [1:0] REG_MFG_SECOND = 2'd1;
  localparam logic [1:0] REG_MFG_THIRD  = 2'd2;
  localparam logic [1:0] REG_MAX_CHUNK  = 2'd3;

  localparam logic [2:0] HDR_SOF        = 3'd0;
  localparam logic [2:0] HDR_MFG_FIRST  = 3'd1;
  localparam logic [2:0] HDR_MFG_SECOND = 3'd2;
  localparam logic [2:0] HDR_MFG_THIRD  = 3'd3;
  localparam logic [2:0] HDR_FLAG       = 3'd4;
  localparam logic [2:0] HDR_LEN        = 3'd5;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HEAD,
    BK_DATA,
    BK_CLOSE
  } back_state_t;

  typedef struct packed {
    logic [6:0]       mfg_first;
    logic [6:0]       mfg_second;
    logic [6:0]       mfg_third;
    logic [IDX_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic             has_cont;
    logic             cont_first;
    logic             cont_bank;
    logic [IDX_W-1:0] cont_len;
    logic             has_final;
    logic             final_first;
    logic             final_bank;
    logic [IDX_W-1:0] final_len;
  } item_cmd_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } wr_t;

  typedef struct packed {
    logic done;
    logic bank;
  } done_t;

endpackage
`default_nettype wire

[rtl/scf_in_if.sv]
// Input request channel carrying one payload byte and its end-of-message flag.
`default_nettype none
interface scf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       msg_last;

  modport source (output valid, output data_byte, output msg_last, input ready);
  modport sink (input valid, input data_byte, input msg_last, output ready);
endinterface
`default_nettype wire

[rtl/scf_out_if.sv]
// Output request channel carrying one byte of the framed SysEx stream.
`default_nettype none
interface scf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_close;
  logic       run_last;

  modport source (output valid, output out_byte, output frame_close, output run_last,
                  input ready);
  modport sink (input valid, input out_byte, input frame_close, input run_last,
                output ready);
endinterface
`default_nettype wire

[rtl/scf_front.sv]
// Front end: accepts payload bytes, fills the store banks and issues frame commands.
`default_nettype none
module scf_front (
  input  logic              clk,
  input  logic              rst_n,
  scf_in_if.sink            in_stream,
  input  scf_pkg::cfg_t     cfg,
  input  scf_pkg::done_t    done,
  input  logic              q_full,
  output logic              q_push,
  output scf_pkg::item_cmd_t q_cmd,
  output scf_pkg::wr_t      wr
);

  logic [scf_pkg::IDX_W-1:0] fill_r, fill_nxt;
  logic                      first_r, first_nxt;
  logic                      wbank_r, wbank_nxt;
  logic [1:0]                busy_r, busy_nxt;

  logic                      cont;
  logic                      tbank;
  logic                      acc;
  logic [scf_pkg::IDX_W-1:0] fill_after;

  assign cont            = fill_r >= cfg.limit;
  assign tbank           = cont ? ~wbank_r : wbank_r;
  assign in_stream.ready = !q_full && !busy_r[tbank];
  assign acc             = in_stream.valid && in_stream.ready;
  assign fill_after      = cont ? scf_pkg::IDX_W'(1) : fill_r + scf_pkg::IDX_W'(1);

  always_comb begin
    wr.en   = acc;
    wr.bank = tbank;
    wr.idx  = cont ? '0 : fill_r;
    wr.data = in_stream.data_byte;

    q_cmd.has_cont    = cont;
    q_cmd.cont_first  = first_r;
    q_cmd.cont_bank   = wbank_r;
    q_cmd.cont_len    = fill_r;
    q_cmd.has_final   = in_stream.msg_last;
    q_cmd.final_first = cont ? 1'b0 : first_r;
    q_cmd.final_bank  = tbank;
    q_cmd.final_len   = fill_after;

    q_push = acc && (cont || in_stream.msg_last);
  end

  always_comb begin
    fill_nxt  = fill_r;
    first_nxt = first_r;
    wbank_nxt = wbank_r;
    busy_nxt  = busy_r;
    if (done.done) begin
      busy_nxt[done.bank] = 1'b0;
    end
    if (acc) begin
      if (in_stream.msg_last) begin
        fill_nxt  = '0;
        first_nxt = 1'b1;
        wbank_nxt = ~tbank;
        busy_nxt[tbank] = 1'b1;
      end else begin
        fill_nxt  = fill_after;
        first_nxt = cont ? 1'b0 : first_r;
        wbank_nxt = tbank;
      end
      if (cont) begin
        busy_nxt[wbank_r] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      first_r <= 1'b1;
      wbank_r <= 1'b0;
      busy_r  <= '0;
    end else begin
      fill_r  <= fill_nxt;
      first_r <= first_nxt;
      wbank_r <= wbank_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/scf_cmd_q.sv]
// Short command queue between the front end and the frame sender.
`default_nettype none
module scf_cmd_q (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  scf_pkg::item_cmd_t push_cmd,
  input  logic               pop,
  output scf_pkg::item_cmd_t head_cmd,
  output logic               full,
  output logic               empty
);

  scf_pkg::item_cmd_t          entries_r [scf_pkg::Q_DEPTH];
  logic [scf_pkg::Q_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [scf_pkg::Q_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [scf_pkg::Q_PTR_W:0]   count_r, count_nxt;

  assign full     = count_r == (scf_pkg::Q_PTR_W+1)'(scf_pkg::Q_DEPTH);
  assign empty    = count_r == '0;
  assign head_cmd = entries_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/scf_back.sv]
// Frame sender: holds the byte store and emits the frames of each queued command.
`default_nettype none
module scf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  scf_pkg::cfg_t      cfg,
  input  scf_pkg::wr_t       wr,
  input  logic               q_empty,
  input  scf_pkg::item_cmd_t q_cmd,
  output logic               q_pop,
  output scf_pkg::done_t     done,
  scf_out_if.source          out_stream
);

  logic [7:0] store_r [2][scf_pkg::CHUNK_MAX];
  logic [7:0] mem_q_r;

  scf_pkg::back_state_t      state_r, state_nxt;
  logic [2:0]                pos_r, pos_nxt;
  logic [scf_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                      phase_r, phase_nxt;
  scf_pkg::item_cmd_t        cur_r, cur_nxt;
  logic                      bank_nxt;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_close_r;
  logic       out_last_r;

  logic                      f_final;
  logic                      f_first;
  logic                      f_bank;
  logic                      f_last;
  logic [scf_pkg::IDX_W-1:0] f_len;
  logic                      step;
  logic [7:0]                byte_sel;
  logic                      close_sel;
  logic                      last_sel;

  assign f_final  = phase_r;
  assign f_first  = phase_r ? cur_r.final_first : cur_r.cont_first;
  assign f_bank   = phase_r ? cur_r.final_bank : cur_r.cont_bank;
  assign f_len    = phase_r ? cur_r.final_len : cur_r.cont_len;
  assign f_last   = phase_r || !cur_r.has_final;
  assign step     = (state_r != scf_pkg::BK_IDLE) && (!out_valid_r || out_stream.ready);
  assign bank_nxt = phase_nxt ? cur_nxt.final_bank : cur_nxt.cont_bank;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    cur_nxt   = cur_r;
    case (state_r)
      scf_pkg::BK_IDLE: begin
        if (!q_empty) begin
          cur_nxt   = q_cmd;
          phase_nxt = !q_cmd.has_cont;
          pos_nxt   = scf_pkg::HDR_SOF;
          idx_nxt   = '0;
          state_nxt = scf_pkg::BK_HEAD;
        end
      end
      scf_pkg::BK_HEAD: begin
        if (step) begin
          if (pos_r == scf_pkg::HDR_LEN) begin
            state_nxt = scf_pkg::BK_DATA;
          end else begin
            pos_nxt = pos_r + 3'd1;
          end
        end
      end
      scf_pkg::BK_DATA: begin
        if (step) begin
          if (idx_r == f_len - scf_pkg::IDX_W'(1)) begin
            state_nxt = scf_pkg::BK_CLOSE;
          end else begin
            idx_nxt = idx_r + scf_pkg::IDX_W'(1);
          end
        end
      end
      scf_pkg::BK_CLOSE: begin
        if (step) begin
          if (f_last) begin
            state_nxt = scf_pkg::BK_IDLE;
          end else begin
            phase_nxt = 1'b1;
            pos_nxt   = scf_pkg::HDR_SOF;
            idx_nxt   = '0;
            state_nxt = scf_pkg::BK_HEAD;
          end
        end
      end
      default: begin
        state_nxt = scf_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop     = (state_r == scf_pkg::BK_IDLE) && !q_empty;
    done.done = step && (state_r == scf_pkg::BK_CLOSE);
    done.bank = f_bank;
    byte_sel  = 8'h00;
    close_sel = 1'b0;
    last_sel  = 1'b0;
    case (state_r)
      scf_pkg::BK_HEAD: begin
        case (pos_r)
          scf_pkg::HDR_SOF:        byte_sel = scf_pkg::SOF_BYTE;
          scf_pkg::HDR_MFG_FIRST:  byte_sel = {1'b0, cfg.mfg_first};
          scf_pkg::HDR_MFG_SECOND: byte_sel = {1'b0, cfg.mfg_second};
          scf_pkg::HDR_MFG_THIRD:  byte_sel = {1'b0, cfg.mfg_third};
          scf_pkg::HDR_FLAG: begin
            byte_sel = (f_final ? scf_pkg::FLAG_FINAL : scf_pkg::FLAG_CONT) | {7'b0, f_first};
          end
          scf_pkg::HDR_LEN:        byte_sel = {2'b00, f_len};
          default:                 byte_sel = 8'h00;
        endcase
      end
      scf_pkg::BK_DATA: begin
        byte_sel = mem_q_r;
      end
      scf_pkg::BK_CLOSE: begin
        byte_sel  = scf_pkg::EOF_BYTE;
        close_sel = 1'b1;
        last_sel  = f_last;
      end
      default: begin
        byte_sel = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      store_r[wr.bank][wr.idx] <= wr.data;
    end
    mem_q_r <= store_r[bank_nxt][idx_nxt];
    cur_r   <= cur_nxt;
    pos_r   <= pos_nxt;
    idx_r   <= idx_nxt;
    if (step) begin
      out_byte_r  <= byte_sel;
      out_close_r <= close_sel;
      out_last_r  <= last_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scf_pkg::BK_IDLE;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_stream.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_stream.valid       = out_valid_r;
  assign out_stream.out_byte    = out_byte_r;
  assign out_stream.frame_close = out_close_r;
  assign out_stream.run_last    = out_last_r;

endmodule
`default_nettype wire

[rtl/sysex_chunk_framer_unit.sv]
// Top level of the SysEx chunk framer with its configuration registers.
// A byte that closes a frame leaves a command for the frame sender, which puts out one
// byte per cycle while the output is ready: a frame of n payload bytes is n + 7 bytes
// long. The input stalls only while the two-entry command queue is full or while the
// store bank that the next byte goes to is still queued or being read out; the store
// has two banks of 48 bytes so that one chunk is sent while the next one fills.
`default_nettype none
module sysex_chunk_framer_unit (
  input  logic        clk,
  input  logic        rst_n,
  scf_in_if.sink      in_stream,
  scf_out_if.source   out_stream,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [6:0]                mfg_first_r;
  logic [6:0]                mfg_second_r;
  logic [6:0]                mfg_third_r;
  logic [scf_pkg::IDX_W-1:0] max_chunk_r;
  logic                      cfg_wr;
  logic [1:0]                reg_idx;

  scf_pkg::cfg_t      cfg;
  scf_pkg::wr_t       wr;
  scf_pkg::done_t     done;
  scf_pkg::item_cmd_t push_cmd;
  scf_pkg::item_cmd_t head_cmd;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    case (reg_idx)
      scf_pkg::REG_MFG_FIRST:  prdata = {25'b0, mfg_first_r};
      scf_pkg::REG_MFG_SECOND: prdata = {25'b0, mfg_second_r};
      scf_pkg::REG_MFG_THIRD:  prdata = {25'b0, mfg_third_r};
      scf_pkg::REG_MAX_CHUNK:  prdata = {26'b0, max_chunk_r};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mfg_first_r  <= '0;
      mfg_second_r <= '0;
      mfg_third_r  <= '0;
      max_chunk_r  <= scf_pkg::IDX_W'(scf_pkg::CHUNK_MAX);
    end else if (cfg_wr) begin
      case (reg_idx)
        scf_pkg::REG_MFG_FIRST:  mfg_first_r  <= pwdata[6:0];
        scf_pkg::REG_MFG_SECOND: mfg_second_r <= pwdata[6:0];
        scf_pkg::REG_MFG_THIRD:  mfg_third_r  <= pwdata[6:0];
        scf_pkg::REG_MAX_CHUNK:  max_chunk_r  <= pwdata[scf_pkg::IDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.mfg_first  = mfg_first_r;
    cfg.mfg_second = mfg_second_r;
    cfg.mfg_third  = mfg_third_r;
    if (max_chunk_r == '0) begin
      cfg.limit = scf_pkg::IDX_W'(1);
    end else if (max_chunk_r > scf_pkg::IDX_W'(scf_pkg::CHUNK_MAX)) begin
      cfg.limit = scf_pkg::IDX_W'(scf_pkg::CHUNK_MAX);
    end else begin
      cfg.limit = max_chunk_r;
    end
  end

  scf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_stream),
    .cfg       (cfg),
    .done      (done),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .wr        (wr)
  );

  scf_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  scf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .wr         (wr),
    .q_empty    (q_empty),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .done       (done),
    .out_stream (out_stream)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from an empty queue");

  a_done_shows_close: assert property (@(posedge clk) disable iff (!rst_n)
    done.done |=> (out_stream.valid && out_stream.frame_close))
    else $error("frame end not followed by a closing byte");

  a_write_avoids_read_bank: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.en && done.done) |-> (wr.bank != done.bank))
    else $error("store bank written while its frame is still being sent");

endmodule
`default_nettype wire
